>>> rtl/ahfe_pkg.sv
// Package with the shared types, codes and helper functions of the ASCII hex frame encoder.
`default_nettype none

package ahfe_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] START_CHAR_RST = 8'd36;
  localparam logic [CHAR_W-1:0] END_CHAR_RST   = 8'd13;

  localparam logic [CFG_IDX_W-1:0] CFG_START_CHAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CHAR   = 1'd1;

  typedef struct packed {
    logic [CHAR_W-1:0] item_byte;
    logic              as_hex;
    logic              frame_last;
    logic              first;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_BODY,
    PH_LO,
    PH_CK_HI,
    PH_CK_LO,
    PH_END
  } phase_t;

  function automatic logic [CHAR_W-1:0] hex_digit(input logic [NIBBLE_W-1:0] nib);
    logic [CHAR_W-1:0] wide;
    wide = {{(CHAR_W-NIBBLE_W){1'b0}}, nib};
    if (nib < 4'd10) begin
      return wide + 8'h30;
    end else begin
      return wide + 8'h37;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/ahfe_if.sv
// Valid/ready channel interfaces for the input items and the output characters.
`default_nettype none

interface ahfe_in_if;
  logic                             valid;
  logic                             ready;
  logic [ahfe_pkg::CHAR_W-1:0]      item_byte;
  logic                             as_hex;
  logic                             frame_last;

  modport source (output valid, output item_byte, output as_hex, output frame_last,
                  input ready);
  modport sink   (input valid, input item_byte, input as_hex, input frame_last,
                  output ready);
endinterface

interface ahfe_out_if;
  logic                             valid;
  logic                             ready;
  logic [ahfe_pkg::CHAR_W-1:0]      out_char;
  logic                             item_last;
  logic                             frame_done;

  modport source (output valid, output out_char, output item_last, output frame_done,
                  input ready);
  modport sink   (input valid, input out_char, input item_last, input frame_done,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/ahfe_fifo.sv
// Small command queue between the front and the back of the encoder.
`default_nettype none

module ahfe_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ahfe_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output ahfe_pkg::cmd_t      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ahfe_pkg::cmd_t    slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ahfe_front.sv
// Front end: accepts item beats and marks the ones that open a new frame.
`default_nettype none

module ahfe_front (
  input  wire logic      clk,
  input  wire logic      rst_n,
  ahfe_in_if.sink        in_ch,
  input  wire logic      q_full,
  output logic           q_push,
  output ahfe_pkg::cmd_t q_data
);

  logic in_frame_r, in_frame_nxt;
  logic accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign q_push      = accept;

  always_comb begin
    q_data.item_byte  = in_ch.item_byte;
    q_data.as_hex     = in_ch.as_hex;
    q_data.frame_last = in_ch.frame_last;
    q_data.first      = !in_frame_r;
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    if (accept) begin
      in_frame_nxt = !in_ch.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ahfe_back.sv
// Back end: steps through the characters of each queued item and keeps the checksum.
`default_nettype none

module ahfe_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire ahfe_pkg::cmd_t              q_data,
  output logic                             q_pop,
  input  wire logic [ahfe_pkg::CHAR_W-1:0] start_char,
  input  wire logic [ahfe_pkg::CHAR_W-1:0] end_char,
  ahfe_out_if.source                       out_ch
);

  ahfe_pkg::phase_t             phase_r, phase_nxt, phase_eff;
  logic [ahfe_pkg::CHAR_W-1:0]  xor_r, xor_nxt;
  logic [ahfe_pkg::CHAR_W-1:0]  char_sel;
  logic                         last_sel;
  logic                         done_sel;
  logic                         pop_sel;
  logic                         clear_sum;
  logic                         step;
  logic                         out_valid_r;
  logic [ahfe_pkg::CHAR_W-1:0]  out_char_r;
  logic                         item_last_r;
  logic                         frame_done_r;

  assign step = q_valid && (!out_valid_r || out_ch.ready);

  assign phase_eff = (phase_r == ahfe_pkg::PH_FIRST && !q_data.first) ?
                     ahfe_pkg::PH_BODY : phase_r;

  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      unique case (phase_eff)
        ahfe_pkg::PH_FIRST: phase_nxt = ahfe_pkg::PH_BODY;
        ahfe_pkg::PH_BODY: begin
          if (q_data.as_hex) begin
            phase_nxt = ahfe_pkg::PH_LO;
          end else begin
            phase_nxt = q_data.frame_last ? ahfe_pkg::PH_CK_HI : ahfe_pkg::PH_FIRST;
          end
        end
        ahfe_pkg::PH_LO:
          phase_nxt = q_data.frame_last ? ahfe_pkg::PH_CK_HI : ahfe_pkg::PH_FIRST;
        ahfe_pkg::PH_CK_HI: phase_nxt = ahfe_pkg::PH_CK_LO;
        ahfe_pkg::PH_CK_LO: phase_nxt = ahfe_pkg::PH_END;
        ahfe_pkg::PH_END:   phase_nxt = ahfe_pkg::PH_FIRST;
        default:            phase_nxt = ahfe_pkg::PH_FIRST;
      endcase
    end
  end

  always_comb begin
    char_sel  = '0;
    last_sel  = 1'b0;
    done_sel  = 1'b0;
    pop_sel   = 1'b0;
    clear_sum = 1'b0;
    unique case (phase_eff)
      ahfe_pkg::PH_FIRST: begin
        char_sel  = start_char;
        clear_sum = 1'b1;
      end
      ahfe_pkg::PH_BODY: begin
        if (q_data.as_hex) begin
          char_sel = ahfe_pkg::hex_digit(q_data.item_byte[7:4]);
        end else begin
          char_sel = q_data.item_byte;
          last_sel = !q_data.frame_last;
          pop_sel  = !q_data.frame_last;
        end
      end
      ahfe_pkg::PH_LO: begin
        char_sel = ahfe_pkg::hex_digit(q_data.item_byte[3:0]);
        last_sel = !q_data.frame_last;
        pop_sel  = !q_data.frame_last;
      end
      ahfe_pkg::PH_CK_HI: char_sel = ahfe_pkg::hex_digit(xor_r[7:4]);
      ahfe_pkg::PH_CK_LO: char_sel = ahfe_pkg::hex_digit(xor_r[3:0]);
      ahfe_pkg::PH_END: begin
        char_sel  = end_char;
        last_sel  = 1'b1;
        done_sel  = 1'b1;
        pop_sel   = 1'b1;
        clear_sum = 1'b1;
      end
      default: char_sel = '0;
    endcase
  end

  always_comb begin
    xor_nxt = xor_r;
    if (step) begin
      if (clear_sum) begin
        xor_nxt = '0;
      end else if (phase_eff == ahfe_pkg::PH_BODY || phase_eff == ahfe_pkg::PH_LO) begin
        xor_nxt = xor_r ^ char_sel;
      end
    end
  end

  assign q_pop = step && pop_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ahfe_pkg::PH_FIRST;
      xor_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_char_r   <= char_sel;
      item_last_r  <= last_sel;
      frame_done_r <= done_sel;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_char   = out_char_r;
  assign out_ch.item_last  = item_last_r;
  assign out_ch.frame_done = frame_done_r;

endmodule

`default_nettype wire

>>> rtl/ascii_hex_frame_encoder_top.sv
// Top level of the ASCII hex frame encoder with XOR checksum.
//
//   Channel  Direction  Beat carries
//   in_ch    sink       item_byte, as_hex, frame_last
//   out_ch   source     out_char, item_last, frame_done
//   cfg_*    write      cfg_index selects start_char or end_char, cfg_wdata
//
// The back end sends one character per cycle while neither side stalls. An item
// gives 1 to 6 characters: one raw character or two hex digits, one more for the
// start character and three for the checksum and end character. The front end
// accepts a new item every cycle while the queue has room. Reset is synchronous
// and leaves the encoder idle between frames. Either side may stall on its own.
`default_nettype none

module ascii_hex_frame_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ahfe_in_if.sink                             in_ch,
  ahfe_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [ahfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ahfe_pkg::CHAR_W-1:0]    cfg_wdata
);

  logic [ahfe_pkg::CHAR_W-1:0] start_char_r;
  logic [ahfe_pkg::CHAR_W-1:0] end_char_r;
  logic                        q_push;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_valid;
  ahfe_pkg::cmd_t              q_in;
  ahfe_pkg::cmd_t              q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= ahfe_pkg::START_CHAR_RST;
      end_char_r   <= ahfe_pkg::END_CHAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ahfe_pkg::CFG_START_CHAR: start_char_r <= cfg_wdata;
        ahfe_pkg::CFG_END_CHAR:   end_char_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ahfe_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  ahfe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  ahfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_head),
    .q_pop      (q_pop),
    .start_char (start_char_r),
    .end_char   (end_char_r),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/ahfe_checker.sv
// Port-level checker for the frame encoder, bound to the top level.
`default_nettype none

module ahfe_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [ahfe_pkg::CHAR_W-1:0] out_char,
  input wire logic                        item_last,
  input wire logic                        frame_done
);

  logic after_done_r;
  logic out_beat;

  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      after_done_r <= 1'b0;
    end else if (out_beat) begin
      after_done_r <= frame_done;
    end
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Output valid dropped while stalled.");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_char) && $stable(item_last) && $stable(frame_done))
    else $error("Output payload changed while stalled.");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_done |-> item_last)
    else $error("End character not marked as the last of its item.");

  a_start_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && after_done_r |-> !item_last && !frame_done)
    else $error("The beat after a closed frame is not a start character.");

endmodule

bind ascii_hex_frame_encoder_top ahfe_checker u_ahfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_char   (out_ch.out_char),
  .item_last  (out_ch.item_last),
  .frame_done (out_ch.frame_done)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the ASCII hex frame encoder, with directed and random frames.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [ahfe_pkg::CHAR_W-1:0] ch;
    logic                        item_last;
    logic                        frame_done;
  } frame_char_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [ahfe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ahfe_pkg::CHAR_W-1:0]    cfg_wdata;

  ahfe_in_if  in_ch ();
  ahfe_out_if out_ch ();

  ascii_hex_frame_encoder_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  frame_char_t                 pending_chars[$];
  logic [ahfe_pkg::CHAR_W-1:0] start_char_m;
  logic [ahfe_pkg::CHAR_W-1:0] end_char_m;
  logic [ahfe_pkg::CHAR_W-1:0] body_xor;
  logic                        frame_open;
  bit                          stalls_on;
  int                          err_count = 0;
  int                          cycle_count = 0;
  int                          stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [ahfe_pkg::CHAR_W-1:0] hex_char(
      input logic [ahfe_pkg::NIBBLE_W-1:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end else begin
      return 8'h41 + {4'h0, nib} - 8'd10;
    end
  endfunction

  function automatic void queue_chars(input logic [ahfe_pkg::CHAR_W-1:0] b, input logic h,
                                      input logic l);
    frame_char_t c;
    if (!frame_open) begin
      c = '{start_char_m, 1'b0, 1'b0};
      pending_chars.push_back(c);
      body_xor   = '0;
      frame_open = 1'b1;
    end
    if (h) begin
      body_xor = body_xor ^ hex_char(b[7:4]) ^ hex_char(b[3:0]);
      c = '{hex_char(b[7:4]), 1'b0, 1'b0};
      pending_chars.push_back(c);
      c = '{hex_char(b[3:0]), !l, 1'b0};
      pending_chars.push_back(c);
    end else begin
      body_xor = body_xor ^ b;
      c = '{b, !l, 1'b0};
      pending_chars.push_back(c);
    end
    if (l) begin
      c = '{hex_char(body_xor[7:4]), 1'b0, 1'b0};
      pending_chars.push_back(c);
      c = '{hex_char(body_xor[3:0]), 1'b0, 1'b0};
      pending_chars.push_back(c);
      c = '{end_char_m, 1'b1, 1'b1};
      pending_chars.push_back(c);
      body_xor   = '0;
      frame_open = 1'b0;
    end
  endfunction

  task automatic send_item(input logic [ahfe_pkg::CHAR_W-1:0] b, input logic h,
                           input logic l);
    int gap;
    gap = (stalls_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.item_byte  <= b;
    in_ch.as_hex     <= h;
    in_ch.frame_last <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    queue_chars(b, h, l);
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ahfe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ahfe_pkg::CHAR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ahfe_pkg::CFG_START_CHAR) begin
      start_char_m = val;
    end else begin
      end_char_m = val;
    end
  endtask

  task automatic test_default_chars();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h41, 1'b0, 1'b1);
    wait_until_drained();
  endtask

  task automatic test_field_extremes();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hA5, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h9C, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    wait_until_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(ahfe_pkg::CFG_START_CHAR, 8'h00);
    write_reg(ahfe_pkg::CFG_END_CHAR, 8'hFF);
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'hED, 1'b0, 1'b1);
    wait_until_drained();
    write_reg(ahfe_pkg::CFG_START_CHAR, 8'hFF);
    write_reg(ahfe_pkg::CFG_END_CHAR, 8'h00);
    send_item(8'h80, 1'b0, 1'b1);
    // The end character is changed while a frame is still open.
    send_item(8'h3C, 1'b1, 1'b0);
    wait_until_drained();
    write_reg(ahfe_pkg::CFG_END_CHAR, 8'h0A);
    write_reg(ahfe_pkg::CFG_START_CHAR, 8'h55);
    send_item(8'hC3, 1'b0, 1'b1);
    send_item(8'h01, 1'b1, 1'b1);
    wait_until_drained();
  endtask

  task automatic test_random_frames();
    int  sent;
    int  n;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < 400) begin
      if (sent >= 320) begin
        stalls_on = 1'b0;
      end
      if (!paused && sent >= 200) begin
        wait_until_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        wait_until_drained();
        write_reg(ahfe_pkg::CFG_START_CHAR, 8'($urandom_range(0, 255)));
        write_reg(ahfe_pkg::CFG_END_CHAR, 8'($urandom_range(0, 255)));
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), i == n - 1);
      end
      sent += n;
    end
    wait_until_drained();
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(1, 10) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected beat, actual char %h item_last %b frame_done %b", $time,
                 out_ch.out_char, out_ch.item_last, out_ch.frame_done);
        err_count++;
      end else begin
        want = pending_chars.pop_front();
        if (want.ch !== out_ch.out_char) begin
          $display("%0t: out_char expected %h actual %h", $time, want.ch, out_ch.out_char);
          err_count++;
        end
        if (want.item_last !== out_ch.item_last) begin
          $display("%0t: item_last expected %b actual %b", $time, want.item_last,
                   out_ch.item_last);
          err_count++;
        end
        if (want.frame_done !== out_ch.frame_done) begin
          $display("%0t: frame_done expected %b actual %b", $time, want.frame_done,
                   out_ch.frame_done);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d characters outstanding", $time, pending_chars.size());
      $display("ascii_hex_frame_encoder_top: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.item_byte  = '0;
    in_ch.as_hex     = 1'b0;
    in_ch.frame_last = 1'b0;
    out_ch.ready     = 1'b0;
    start_char_m     = ahfe_pkg::START_CHAR_RST;
    end_char_m       = ahfe_pkg::END_CHAR_RST;
    body_xor         = '0;
    frame_open       = 1'b0;
    stalls_on        = 1'b1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_default_chars();
    test_field_extremes();
    test_register_extremes();
    test_random_frames();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("ascii_hex_frame_encoder_top: match");
    end else begin
      $display("ascii_hex_frame_encoder_top: mismatch");
    end
    $finish;
  end

endmodule
